// ----- hw/rtl/bpr_pkg.sv -----
// Package for the binary property list reader.
// Holds command and sequencer state types, format constants and the memory write bundle.
// No dependencies.
package bpr_pkg;

  localparam int DEF_IMAGE_BYTES = 4096;
  localparam int DEF_KEY_BYTES   = 64;

  localparam logic [63:0] MAGIC       = 64'h62706C6973743030;
  localparam int          MAGIC_BYTES = 8;
  localparam int          MIN_IMAGE   = 40;
  localparam int          TRAILER     = 32;
  localparam int          TRL_SIZES   = 6;
  localparam int          TRL_COUNT   = 8;
  localparam int          TRL_ROOT    = 16;
  localparam int          TRL_TABLE   = 24;
  localparam int          MAX_FIELD   = 8;

  localparam logic [3:0] KIND_UINT    = 4'd1;
  localparam logic [3:0] KIND_REAL    = 4'd2;
  localparam logic [3:0] KIND_DATA    = 4'd4;
  localparam logic [3:0] KIND_STRING  = 4'd5;
  localparam logic [3:0] KIND_UNICODE = 4'd6;
  localparam logic [3:0] KIND_ARRAY   = 4'd10;
  localparam logic [3:0] KIND_DICT    = 4'd13;
  localparam logic [3:0] LEN_EXT      = 4'd15;

  typedef enum logic [2:0] {
    CMD_LOAD_IMG = 3'd0,
    CMD_LOAD_KEY = 3'd1,
    CMD_OPEN     = 3'd2,
    CMD_GET      = 3'd3,
    CMD_AT       = 3'd4,
    CMD_COUNT    = 3'd5,
    CMD_UINT     = 3'd6,
    CMD_BYTES    = 3'd7
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DONE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_OPEN_MAGIC,
    S_OPEN_SIZES,
    S_OPEN_CNT,
    S_OPEN_ROOT,
    S_OPEN_TAB,
    S_LOC_START,
    S_LOC_OFF,
    S_LOC_MARK,
    S_LOC_EXT,
    S_LOC_EXTN,
    S_LOC_WIDTH,
    S_LOC_DONE,
    S_UINT_VAL,
    S_AT_REF,
    S_GET_LOOP,
    S_GET_KREF,
    S_GET_NEXT,
    S_GET_CMP_ISSUE,
    S_GET_CMP_WAIT,
    S_GET_CMP,
    S_GET_VAL
  } state_t;

  typedef struct packed {
    logic        img_we;
    logic        key_we;
    logic [11:0] addr;
    logic [7:0]  data;
  } mem_wr_t;

endpackage

// ----- hw/rtl/bpr_mem.sv -----
// Image memory and key buffer of the property list reader.
// Both are synchronous with one write and one registered read port; uses bpr_pkg.
module bpr_mem import bpr_pkg::*; #(
  parameter int IMAGE_BYTES = DEF_IMAGE_BYTES,
  parameter int KEY_BYTES   = DEF_KEY_BYTES,
  localparam int AW = $clog2(IMAGE_BYTES),
  localparam int KW = $clog2(KEY_BYTES)
) (
  input  logic          clk,
  input  mem_wr_t       wr,
  input  logic [AW-1:0] img_raddr,
  input  logic [KW-1:0] key_raddr,
  output logic [7:0]    img_q,
  output logic [7:0]    key_q
);

  logic [7:0] img_mem [IMAGE_BYTES];
  logic [7:0] key_mem [KEY_BYTES];

  always_ff @(posedge clk) begin
    if (wr.img_we) begin
      img_mem[AW'(wr.addr)] <= wr.data;
    end
    img_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[KW'(wr.addr)] <= wr.data;
    end
    key_q <= key_mem[key_raddr];
  end

endmodule

// ----- hw/rtl/bpr_ctrl.sv -----
// Command sequencer of the property list reader: trailer check, offset table walk,
// marker decode, key search and the result register. Uses bpr_pkg; drives bpr_mem.
module bpr_ctrl import bpr_pkg::*; #(
  parameter int IMAGE_BYTES = DEF_IMAGE_BYTES,
  parameter int KEY_BYTES   = DEF_KEY_BYTES,
  localparam int AW = $clog2(IMAGE_BYTES),
  localparam int PW = AW + 1,
  localparam int KW = $clog2(KEY_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,
  output logic          out_tuser,
  output mem_wr_t       mem_wr,
  output logic [AW-1:0] img_raddr,
  output logic [KW-1:0] key_raddr,
  input  logic [7:0]    img_q,
  input  logic [7:0]    key_q
);

  logic [7:0]  f_byte;
  logic [11:0] f_addr;
  logic [12:0] f_size;
  logic [11:0] f_oref;
  logic [11:0] f_idx;
  logic [6:0]  f_klen;

  assign f_byte = in_tdata[7:0];
  assign f_addr = in_tdata[19:8];
  assign f_size = in_tdata[32:20];
  assign f_oref = in_tdata[44:33];
  assign f_idx  = in_tdata[56:45];
  assign f_klen = in_tdata[63:57];

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [11:0]   idx_r, idx_nxt;
  logic [6:0]    klen_r, klen_nxt;
  logic          opened_r, opened_nxt;
  logic [PW-1:0] tab_r, tab_nxt, ocnt_r, ocnt_nxt, root_r, root_nxt;
  logic [3:0]    osz_r, osz_nxt, rsz_r, rsz_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [7:0]    t_osz_r, t_osz_nxt, t_rsz_r, t_rsz_nxt;
  logic [63:0]   t_cnt_r, t_cnt_nxt, t_root_r, t_root_nxt;
  logic [PW-1:0] rd_addr_r, rd_addr_nxt;
  logic [3:0]    rd_left_r, rd_left_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [PW-1:0] lref_r, lref_nxt, pos_r, pos_nxt;
  logic          loc_key_r, loc_key_nxt;
  logic [63:0]   n_r, n_nxt;
  logic [3:0]    kind_r, kind_nxt;
  logic [PW-1:0] dn_r, dn_nxt, i_r, i_nxt, kaddr_r, kaddr_nxt, voff_r, voff_nxt;
  logic [6:0]    j_r, j_nxt;
  logic          res_st_r, res_st_nxt;
  logic [11:0]   res_ref_r, res_ref_nxt, res_start_r, res_start_nxt;
  logic [12:0]   res_cnt_r, res_cnt_nxt;
  logic [63:0]   res_val_r, res_val_nxt;
  logic          out_valid_r, out_valid_nxt, out_st_r, out_st_nxt;
  logic [11:0]   out_ref_r, out_ref_nxt, out_start_r, out_start_nxt;
  logic [12:0]   out_cnt_r, out_cnt_nxt;
  logic [63:0]   out_val_r, out_val_nxt;

  logic          out_free, fin_fail, loc_fail, load_done;
  logic          rd_go;
  logic [PW-1:0] rd_go_addr;
  logic [3:0]    rd_go_len;
  state_t        rd_go_ret;

  logic [4:0]    width_w;
  logic [PW+4:0] lw_prod, lw_room;
  logic [PW+3:0] oc_prod, oc_room;
  logic [3:0]    elen;
  logic [PW-1:0] ext_pos;

  assign out_free = !out_valid_r || out_tready;
  assign oc_prod  = (PW+4)'(t_cnt_r[PW-1:0]) * (PW+4)'(t_osz_r[3:0]);
  assign oc_room  = (PW+4)'(tail_r - acc_r[PW-1:0]);
  assign lw_prod  = (PW+5)'(n_r[PW-1:0]) * (PW+5)'(width_w);
  assign lw_room  = (PW+5)'(tab_r - pos_r);
  assign elen     = 4'd1 << acc_r[1:0];
  assign ext_pos  = pos_r + PW'(1);

  always_comb begin
    case (kind_r)
      KIND_UNICODE: width_w = 5'd2;
      KIND_ARRAY:   width_w = 5'(rsz_r);
      KIND_DICT:    width_w = {rsz_r, 1'b0};
      default:      width_w = 5'd1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;     ret_nxt = ret_r;       cmd_nxt = cmd_r;
    idx_nxt = idx_r;         klen_nxt = klen_r;     opened_nxt = opened_r;
    tab_nxt = tab_r;         ocnt_nxt = ocnt_r;     root_nxt = root_r;
    osz_nxt = osz_r;         rsz_nxt = rsz_r;       tail_nxt = tail_r;
    t_osz_nxt = t_osz_r;     t_rsz_nxt = t_rsz_r;   t_cnt_nxt = t_cnt_r;
    t_root_nxt = t_root_r;   rd_addr_nxt = rd_addr_r; rd_left_nxt = rd_left_r;
    acc_nxt = acc_r;         lref_nxt = lref_r;     pos_nxt = pos_r;
    loc_key_nxt = loc_key_r; n_nxt = n_r;           kind_nxt = kind_r;
    dn_nxt = dn_r;           i_nxt = i_r;           kaddr_nxt = kaddr_r;
    voff_nxt = voff_r;       j_nxt = j_r;
    res_st_nxt = res_st_r;   res_ref_nxt = res_ref_r; res_cnt_nxt = res_cnt_r;
    res_val_nxt = res_val_r; res_start_nxt = res_start_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt = out_st_r;   out_ref_nxt = out_ref_r; out_cnt_nxt = out_cnt_r;
    out_val_nxt = out_val_r; out_start_nxt = out_start_r;
    mem_wr = '{img_we: 1'b0, key_we: 1'b0, addr: f_addr, data: f_byte};
    in_tready = (state_r == S_IDLE);
    fin_fail = 1'b0; loc_fail = 1'b0; load_done = 1'b0;
    rd_go = 1'b0; rd_go_addr = '0; rd_go_len = '0; rd_go_ret = S_IDLE;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = cmd_t'(in_tuser);
          idx_nxt = f_idx;
          klen_nxt = f_klen;
          res_st_nxt = 1'b0; res_ref_nxt = '0; res_cnt_nxt = '0;
          res_val_nxt = '0; res_start_nxt = '0;
          unique case (cmd_t'(in_tuser))
            CMD_LOAD_IMG: begin
              mem_wr.img_we = 32'(f_addr) < 32'(IMAGE_BYTES);
              load_done = 1'b1;
            end
            CMD_LOAD_KEY: begin
              mem_wr.key_we = 32'(f_addr) < 32'(KEY_BYTES);
              load_done = 1'b1;
            end
            CMD_OPEN: begin
              opened_nxt = 1'b0;
              if (32'(f_size) < 32'(MIN_IMAGE) || 32'(f_size) > 32'(IMAGE_BYTES)) begin
                fin_fail = 1'b1;
              end else begin
                tail_nxt = PW'(32'(f_size) - 32'(TRAILER));
                rd_go = 1'b1; rd_go_addr = '0;
                rd_go_len = 4'(MAGIC_BYTES); rd_go_ret = S_OPEN_MAGIC;
              end
            end
            default: begin
              if (opened_r && 32'(f_oref) < 32'(ocnt_r)) begin
                lref_nxt = PW'(f_oref);
                loc_key_nxt = 1'b0;
                state_nxt = S_LOC_START;
              end else begin
                fin_fail = 1'b1;
              end
            end
          endcase
          if (load_done && !out_free) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r; out_ref_nxt = res_ref_r; out_cnt_nxt = res_cnt_r;
          out_val_nxt = res_val_r; out_start_nxt = res_start_r;
          state_nxt = S_IDLE;
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        acc_nxt = {acc_r[55:0], img_q};
        rd_addr_nxt = rd_addr_r + PW'(1);
        rd_left_nxt = rd_left_r - 4'd1;
        state_nxt = (rd_left_r == 4'd1) ? ret_r : S_RD_ISSUE;
      end
      S_OPEN_MAGIC: begin
        if (acc_r != MAGIC) begin
          fin_fail = 1'b1;
        end else begin
          rd_go = 1'b1; rd_go_addr = tail_r + PW'(TRL_SIZES);
          rd_go_len = 4'd2; rd_go_ret = S_OPEN_SIZES;
        end
      end
      S_OPEN_SIZES: begin
        t_osz_nxt = acc_r[15:8];
        t_rsz_nxt = acc_r[7:0];
        rd_go = 1'b1; rd_go_addr = tail_r + PW'(TRL_COUNT);
        rd_go_len = 4'(MAX_FIELD); rd_go_ret = S_OPEN_CNT;
      end
      S_OPEN_CNT: begin
        t_cnt_nxt = acc_r;
        rd_go = 1'b1; rd_go_addr = tail_r + PW'(TRL_ROOT);
        rd_go_len = 4'(MAX_FIELD); rd_go_ret = S_OPEN_ROOT;
      end
      S_OPEN_ROOT: begin
        t_root_nxt = acc_r;
        rd_go = 1'b1; rd_go_addr = tail_r + PW'(TRL_TABLE);
        rd_go_len = 4'(MAX_FIELD); rd_go_ret = S_OPEN_TAB;
      end
      S_OPEN_TAB: begin
        if (t_osz_r == 8'd0 || t_osz_r > 8'(MAX_FIELD) ||
            t_rsz_r == 8'd0 || t_rsz_r > 8'(MAX_FIELD) ||
            t_cnt_r == 64'd0 || t_root_r >= t_cnt_r ||
            acc_r < 64'(MAGIC_BYTES) || acc_r > 64'(tail_r) ||
            (|t_cnt_r[63:PW]) || oc_prod > oc_room) begin
          fin_fail = 1'b1;
        end else begin
          opened_nxt = 1'b1;
          tab_nxt = acc_r[PW-1:0];
          ocnt_nxt = t_cnt_r[PW-1:0];
          root_nxt = t_root_r[PW-1:0];
          osz_nxt = t_osz_r[3:0];
          rsz_nxt = t_rsz_r[3:0];
          res_ref_nxt = 12'(t_root_r);
          res_cnt_nxt = 13'(t_cnt_r);
          state_nxt = S_DONE;
        end
      end
      S_LOC_START: begin
        rd_go = 1'b1; rd_go_addr = tab_r + lref_r * PW'(osz_r);
        rd_go_len = osz_r; rd_go_ret = S_LOC_OFF;
      end
      S_LOC_OFF: begin
        if (acc_r < 64'(MAGIC_BYTES) || acc_r >= 64'(tab_r)) begin
          loc_fail = 1'b1;
        end else begin
          pos_nxt = acc_r[PW-1:0] + PW'(1);
          rd_go = 1'b1; rd_go_addr = acc_r[PW-1:0];
          rd_go_len = 4'd1; rd_go_ret = S_LOC_MARK;
        end
      end
      S_LOC_MARK: begin
        kind_nxt = acc_r[7:4];
        if (acc_r[7:4] == KIND_UINT || acc_r[7:4] == KIND_REAL) begin
          if (acc_r[3:0] > 4'd3) begin
            loc_fail = 1'b1;
          end else begin
            n_nxt = 64'd1 << acc_r[1:0];
            state_nxt = S_LOC_WIDTH;
          end
        end else if (acc_r[3:0] == LEN_EXT) begin
          if (pos_r >= tab_r) begin
            loc_fail = 1'b1;
          end else begin
            rd_go = 1'b1; rd_go_addr = pos_r;
            rd_go_len = 4'd1; rd_go_ret = S_LOC_EXT;
          end
        end else begin
          n_nxt = 64'(acc_r[3:0]);
          state_nxt = S_LOC_WIDTH;
        end
      end
      S_LOC_EXT: begin
        if (acc_r[7:4] != KIND_UINT || acc_r[3:0] > 4'd3 ||
            PW'(elen) > tab_r - ext_pos) begin
          loc_fail = 1'b1;
        end else begin
          pos_nxt = ext_pos + PW'(elen);
          rd_go = 1'b1; rd_go_addr = ext_pos;
          rd_go_len = elen; rd_go_ret = S_LOC_EXTN;
        end
      end
      S_LOC_EXTN: begin
        n_nxt = acc_r;
        state_nxt = S_LOC_WIDTH;
      end
      S_LOC_WIDTH: begin
        if ((|n_r[63:PW]) || lw_prod > lw_room) begin
          loc_fail = 1'b1;
        end else begin
          state_nxt = S_LOC_DONE;
        end
      end
      S_LOC_DONE: begin
        if (loc_key_r) begin
          if (kind_r == KIND_STRING && n_r == 64'(klen_r)) begin
            j_nxt = '0;
            state_nxt = S_GET_CMP_ISSUE;
          end else begin
            state_nxt = S_GET_NEXT;
          end
        end else begin
          case (cmd_r)
            CMD_COUNT: begin
              if (kind_r == KIND_ARRAY || kind_r == KIND_DICT) begin
                res_cnt_nxt = 13'(n_r);
                state_nxt = S_DONE;
              end else begin
                fin_fail = 1'b1;
              end
            end
            CMD_UINT: begin
              if (kind_r == KIND_UINT) begin
                rd_go = 1'b1; rd_go_addr = pos_r;
                rd_go_len = n_r[3:0]; rd_go_ret = S_UINT_VAL;
              end else begin
                fin_fail = 1'b1;
              end
            end
            CMD_BYTES: begin
              if (kind_r == KIND_DATA || kind_r == KIND_STRING) begin
                res_start_nxt = 12'(pos_r);
                res_cnt_nxt = 13'(n_r);
                state_nxt = S_DONE;
              end else begin
                fin_fail = 1'b1;
              end
            end
            CMD_AT: begin
              if (kind_r == KIND_ARRAY && 64'(idx_r) < n_r) begin
                rd_go = 1'b1; rd_go_addr = pos_r + PW'(idx_r) * PW'(rsz_r);
                rd_go_len = rsz_r; rd_go_ret = S_AT_REF;
              end else begin
                fin_fail = 1'b1;
              end
            end
            CMD_GET: begin
              if (kind_r == KIND_DICT && 32'(klen_r) <= 32'(KEY_BYTES)) begin
                dn_nxt = n_r[PW-1:0];
                i_nxt = '0;
                kaddr_nxt = pos_r;
                voff_nxt = n_r[PW-1:0] * PW'(rsz_r);
                state_nxt = S_GET_LOOP;
              end else begin
                fin_fail = 1'b1;
              end
            end
            default: fin_fail = 1'b1;
          endcase
        end
      end
      S_UINT_VAL: begin
        res_val_nxt = acc_r;
        state_nxt = S_DONE;
      end
      S_AT_REF, S_GET_VAL: begin
        if (acc_r < 64'(ocnt_r)) begin
          res_ref_nxt = 12'(acc_r);
          state_nxt = S_DONE;
        end else begin
          fin_fail = 1'b1;
        end
      end
      S_GET_LOOP: begin
        if (i_r == dn_r) begin
          fin_fail = 1'b1;
        end else begin
          rd_go = 1'b1; rd_go_addr = kaddr_r;
          rd_go_len = rsz_r; rd_go_ret = S_GET_KREF;
        end
      end
      S_GET_KREF: begin
        if (acc_r < 64'(ocnt_r)) begin
          lref_nxt = acc_r[PW-1:0];
          loc_key_nxt = 1'b1;
          state_nxt = S_LOC_START;
        end else begin
          state_nxt = S_GET_NEXT;
        end
      end
      S_GET_NEXT: begin
        i_nxt = i_r + PW'(1);
        kaddr_nxt = kaddr_r + PW'(rsz_r);
        state_nxt = S_GET_LOOP;
      end
      S_GET_CMP_ISSUE: begin
        if (j_r == klen_r) begin
          rd_go = 1'b1; rd_go_addr = kaddr_r + voff_r;
          rd_go_len = rsz_r; rd_go_ret = S_GET_VAL;
        end else begin
          rd_addr_nxt = pos_r + PW'(j_r);
          state_nxt = S_GET_CMP_WAIT;
        end
      end
      S_GET_CMP_WAIT: state_nxt = S_GET_CMP;
      S_GET_CMP: begin
        if (img_q == key_q) begin
          j_nxt = j_r + 7'd1;
          state_nxt = S_GET_CMP_ISSUE;
        end else begin
          state_nxt = S_GET_NEXT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load_done && out_free) begin
      out_valid_nxt = 1'b1;
      out_st_nxt = 1'b0; out_ref_nxt = '0; out_cnt_nxt = '0;
      out_val_nxt = '0; out_start_nxt = '0;
    end
    if (loc_fail) begin
      if (loc_key_r) begin
        state_nxt = S_GET_NEXT;
      end else begin
        fin_fail = 1'b1;
      end
    end
    if (rd_go) begin
      rd_addr_nxt = rd_go_addr;
      rd_left_nxt = rd_go_len;
      acc_nxt = '0;
      ret_nxt = rd_go_ret;
      state_nxt = S_RD_ISSUE;
    end
    if (fin_fail) begin
      res_st_nxt = 1'b1; res_ref_nxt = '0; res_cnt_nxt = '0;
      res_val_nxt = '0; res_start_nxt = '0;
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      opened_r <= 1'b0;
      tab_r <= '0;
      ocnt_r <= '0;
      root_r <= '0;
      osz_r <= '0;
      rsz_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      opened_r <= opened_nxt;
      tab_r <= tab_nxt;
      ocnt_r <= ocnt_nxt;
      root_r <= root_nxt;
      osz_r <= osz_nxt;
      rsz_r <= rsz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;         cmd_r <= cmd_nxt;       idx_r <= idx_nxt;
    klen_r <= klen_nxt;       tail_r <= tail_nxt;     t_osz_r <= t_osz_nxt;
    t_rsz_r <= t_rsz_nxt;     t_cnt_r <= t_cnt_nxt;   t_root_r <= t_root_nxt;
    rd_addr_r <= rd_addr_nxt; rd_left_r <= rd_left_nxt; acc_r <= acc_nxt;
    lref_r <= lref_nxt;       pos_r <= pos_nxt;       loc_key_r <= loc_key_nxt;
    n_r <= n_nxt;             kind_r <= kind_nxt;     dn_r <= dn_nxt;
    i_r <= i_nxt;             kaddr_r <= kaddr_nxt;   voff_r <= voff_nxt;
    j_r <= j_nxt;             res_st_r <= res_st_nxt; res_ref_r <= res_ref_nxt;
    res_cnt_r <= res_cnt_nxt; res_val_r <= res_val_nxt; res_start_r <= res_start_nxt;
    out_st_r <= out_st_nxt;   out_ref_r <= out_ref_nxt; out_cnt_r <= out_cnt_nxt;
    out_val_r <= out_val_nxt; out_start_r <= out_start_nxt;
  end

  assign img_raddr  = rd_addr_r[AW-1:0];
  assign key_raddr  = KW'(j_r);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {3'b000, out_start_r, out_val_r, out_cnt_r, out_ref_r};

  a_open_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(opened_r) |-> $past(state_r == S_OPEN_TAB))
    else $error("opened set outside the trailer check");
  a_sizes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    opened_r |-> (osz_r != 4'd0 && rsz_r != 4'd0 && osz_r <= 4'(MAX_FIELD) &&
                  rsz_r <= 4'(MAX_FIELD)))
    else $error("latched field sizes out of range");
  a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    opened_r |-> root_r < ocnt_r)
    else $error("root reference not below object count");
  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_ISSUE || state_r == S_RD_DATA) |-> rd_left_r != 4'd0)
    else $error("byte reader running with nothing left");

endmodule

// ----- hw/rtl/binary_plist_reader_top.sv -----
// Top level of the binary property list reader.
// Instantiates bpr_ctrl and bpr_mem; uses bpr_pkg.
//
// Usage: in_tuser carries the command, in_tdata its operands. Load commands
// write one image or key byte each and answer with status 0. Open checks the
// magic and the 32-byte trailer and answers with the root reference and the
// object count. Get, at, count, uint and bytes answer with one result item each;
// out_tuser is the status (1 for any failure, with all data fields zero).
// A load with the output free leaves the sequencer idle, so loads stream at one
// item per cycle. Every other command runs on a sequencer that reads the image
// memory byte by byte through its single read port: an open reads the magic and
// the trailer's sizes, count, root and table offset; a locate reads the offset
// entry and the marker, and the extended length when the marker has one; get
// reads each dictionary key's reference, locates it and compares its bytes.
// Reset clears the opened flag and the latched trailer fields; the memories keep
// their contents. A stalled receiver holds the result in the output register; one
// more command is accepted meanwhile and its result waits inside until taken.
module binary_plist_reader_top import bpr_pkg::*; #(
  parameter int IMAGE_BYTES = DEF_IMAGE_BYTES,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // data_byte, byte_address, image_size, object_ref, element_index, key_length
  input  logic [63:0]  in_tdata,
  // command
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ref_out, count_out, value_out, start_out, zero fill
  output logic [103:0] out_tdata,
  // status
  output logic         out_tuser
);

  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int KW = $clog2(KEY_BYTES);

  mem_wr_t       mem_wr;
  logic [AW-1:0] img_raddr;
  logic [KW-1:0] key_raddr;
  logic [7:0]    img_q;
  logic [7:0]    key_q;

  bpr_ctrl #(
    .IMAGE_BYTES(IMAGE_BYTES),
    .KEY_BYTES  (KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .mem_wr    (mem_wr),
    .img_raddr (img_raddr),
    .key_raddr (key_raddr),
    .img_q     (img_q),
    .key_q     (key_q)
  );

  bpr_mem #(
    .IMAGE_BYTES(IMAGE_BYTES),
    .KEY_BYTES  (KEY_BYTES)
  ) u_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .img_raddr(img_raddr),
    .key_raddr(key_raddr),
    .img_q    (img_q),
    .key_q    (key_q)
  );

endmodule
